// ===== rtl/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;
   localparam int PORT_W          = 32;
   localparam int CMD_W           = 4;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int WORD_WIDTH_DEF  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 4'd0,
      CMD_SUB  = 4'd1,
      CMD_MUL  = 4'd2,
      CMD_DIV  = 4'd3,
      CMD_INC  = 4'd4,
      CMD_DEC  = 4'd5,
      CMD_MIN  = 4'd6,
      CMD_MAX  = 4'd7,
      CMD_CMP  = 4'd8,
      CMD_ITOF = 4'd9,
      CMD_FTOI = 4'd10
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/fpa_div.sv =====
`default_nettype none
module fpa_div #(
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [WORD_WIDTH-1:0] num_mag,
   input  logic [WORD_WIDTH-1:0] den_mag,
   input  logic                  quo_neg,
   output logic [WORD_WIDTH-1:0] quo,
   output logic                  quo_ovf
);
   import fpa_pkg::*;

   localparam int W  = WORD_WIDTH;
   localparam int NW = W + FRAC_BITS + 1;

   // The quotient is floor(n * 2^(FRAC_BITS+1) / d) with W+1 bits; rounding halves it afterwards.
   logic [NW-1:0] num_ff;
   logic [W-1:0]  den0_ff;
   logic          neg0_ff;

   logic [W-1:0]  rem_ff [0:W+1];
   logic [W:0]    lq_ff  [0:W+1];
   logic [W-1:0]  den_ff [0:W+1];
   logic          neg_ff [0:W+1];
   logic          ovf_ff [0:W+1];

   logic [W-1:0]  quo_ff;
   logic          quo_ovf_ff;

   logic [NW-1:0] high;
   logic          pre_ovf;

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff  <= {{(NW-W){1'b0}}, num_mag} << (FRAC_BITS + 1);
         den0_ff <= den_mag;
         neg0_ff <= quo_neg;
      end
   end

   // Quotient bits above the W+1 computed ones mean saturation.
   assign high    = num_ff >> (W + 1);
   assign pre_ovf = high >= {{(NW-W){1'b0}}, den0_ff};

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= high[W-1:0];
         lq_ff[0]  <= num_ff[W:0];
         den_ff[0] <= den0_ff;
         neg_ff[0] <= neg0_ff;
         ovf_ff[0] <= pre_ovf;
      end
   end

   for (genvar k = 0; k <= W; k++) begin : g_step
      logic [W:0] trial;
      logic [W:0] diff;
      logic       fits;

      assign trial = {rem_ff[k], lq_ff[k][W]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign fits  = trial >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= fits ? diff[W-1:0] : trial[W-1:0];
            lq_ff[k+1]  <= {lq_ff[k][W-1:0], fits};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   logic [W+1:0] rounded;
   logic [W:0]   qr;
   logic [W:0]   limit;
   logic         sat;
   logic [W-1:0] quo_in;

   always_comb begin
      rounded = ({1'b0, lq_ff[W+1]} + {{(W+1){1'b0}}, 1'b1}) >> 1;
      qr      = rounded[W:0];
      limit   = neg_ff[W+1] ? ({{W{1'b0}}, 1'b1} << (W - 1))
                            : (({{W{1'b0}}, 1'b1} << (W - 1)) - {{W{1'b0}}, 1'b1});
      sat     = ovf_ff[W+1] || (qr > limit);
      if (sat) begin
         quo_in = neg_ff[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         quo_in = neg_ff[W+1] ? (~qr[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : qr[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff     <= quo_in;
         quo_ovf_ff <= sat;
      end
   end

   assign quo     = quo_ff;
   assign quo_ovf = quo_ovf_ff;
endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
`default_nettype none
// Signed fixed-point ALU on WORD_WIDTH-bit raw words with FRAC_BITS fractional bits.
// It accepts one word per clock while req_stall is low; the pipeline depth comes
// from the divider, which resolves one quotient bit per pipeline stage, and all
// other operations are delayed to match so results leave in order. Multiply and
// divide round half away from zero, out-of-range results saturate and raise
// overflow, and divide by zero gives 0 with div_by_zero set. A stalled result
// freezes the whole pipeline, so req_stall follows rsp_stall while a result is
// waiting.
module fixed_point_alu #(
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [fpa_pkg::CMD_W-1:0]    req_cmd,
   input  logic signed [fpa_pkg::PORT_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::PORT_W-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [fpa_pkg::PORT_W-1:0] rsp_result,
   output logic                         rsp_a_greater,
   output logic                         rsp_a_less,
   output logic                         rsp_a_equal,
   output logic                         rsp_div_by_zero,
   output logic                         rsp_overflow
);
   import fpa_pkg::*;

   localparam int W   = WORD_WIDTH;
   localparam int EW  = W + FRAC_BITS;
   localparam int DLY = W + 3;
   localparam logic [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W-1:0] HALF = ({{(2*W-1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;

   typedef struct packed {
      logic         valid;
      logic         is_mul;
      logic         is_div;
      logic         dz;
      logic         gt;
      logic         lt;
      logic         eq;
      logic         ovf;
      logic [W-1:0] result;
   } info_type;

   function automatic logic [W:0] sat_sum(input logic [W:0] s);
      logic [W:0] r;
      if (s[W] != s[W-1]) begin
         r = {1'b1, s[W] ? SAT_LO : SAT_HI};
      end else begin
         r = {1'b0, s[W-1:0]};
      end
      return r;
   endfunction

   logic rsp_valid_ff;
   logic enable;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Input stage.
   logic                a_valid_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic signed [W-1:0] a_ff;
   logic signed [W-1:0] b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cmd_ff <= req_cmd;
         a_ff   <= req_operand_a[W-1:0];
         b_ff   <= req_operand_b[W-1:0];
      end
   end

   // Decode and the combinational operations.
   info_type              info_b_in;
   logic [W:0]            s_add;
   logic [W:0]            s_sub;
   logic [W:0]            s_inc;
   logic [W:0]            s_dec;
   logic signed [EW-1:0]  itof_ext;
   logic                  itof_ok;
   logic signed [2*W-1:0] prod;
   logic [W-1:0]          num_mag;
   logic [W-1:0]          den_mag;

   assign prod    = a_ff * b_ff;
   assign num_mag = a_ff[W-1] ? (~a_ff + {{(W-1){1'b0}}, 1'b1}) : a_ff;
   assign den_mag = b_ff[W-1] ? (~b_ff + {{(W-1){1'b0}}, 1'b1}) : b_ff;

   always_comb begin
      s_add    = sat_sum({a_ff[W-1], a_ff} + {b_ff[W-1], b_ff});
      s_sub    = sat_sum({a_ff[W-1], a_ff} - {b_ff[W-1], b_ff});
      s_inc    = sat_sum({a_ff[W-1], a_ff} + {{W{1'b0}}, 1'b1});
      s_dec    = sat_sum({a_ff[W-1], a_ff} - {{W{1'b0}}, 1'b1});
      itof_ext = EW'(a_ff) <<< FRAC_BITS;
      itof_ok  = (itof_ext[EW-1:W-1] == '0) || (itof_ext[EW-1:W-1] == '1);

      info_b_in        = '0;
      info_b_in.valid  = a_valid_ff;
      info_b_in.gt     = a_ff > b_ff;
      info_b_in.lt     = a_ff < b_ff;
      info_b_in.eq     = a_ff == b_ff;
      unique case (cmd_ff)
         CMD_ADD: begin
            info_b_in.result = s_add[W-1:0];
            info_b_in.ovf    = s_add[W];
         end
         CMD_SUB: begin
            info_b_in.result = s_sub[W-1:0];
            info_b_in.ovf    = s_sub[W];
         end
         CMD_MUL: begin
            info_b_in.is_mul = 1'b1;
         end
         CMD_DIV: begin
            info_b_in.is_div = 1'b1;
            info_b_in.dz     = b_ff == '0;
         end
         CMD_INC: begin
            info_b_in.result = s_inc[W-1:0];
            info_b_in.ovf    = s_inc[W];
         end
         CMD_DEC: begin
            info_b_in.result = s_dec[W-1:0];
            info_b_in.ovf    = s_dec[W];
         end
         CMD_MIN: begin
            info_b_in.result = (a_ff < b_ff) ? a_ff : b_ff;
         end
         CMD_MAX: begin
            info_b_in.result = (a_ff > b_ff) ? a_ff : b_ff;
         end
         CMD_ITOF: begin
            info_b_in.result = itof_ok ? itof_ext[W-1:0]
                                       : (itof_ext[EW-1] ? SAT_LO : SAT_HI);
            info_b_in.ovf    = !itof_ok;
         end
         CMD_FTOI: begin
            info_b_in.result = a_ff >>> FRAC_BITS;
         end
         default: begin
            info_b_in.result = '0;
         end
      endcase
   end

   info_type              info_b_ff;
   logic signed [2*W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         info_b_ff.valid <= 1'b0;
      end else if (enable) begin
         info_b_ff <= info_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod;
      end
   end

   // Multiply rounding: magnitude plus half, folded into one add.
   info_type       info_c_in;
   logic [2*W-1:0] mag_half;
   logic [2*W-1:0] mq;
   logic [2*W-1:0] mlimit;
   logic           msat;
   logic           mneg;

   always_comb begin
      mneg     = prod_ff[2*W-1];
      mag_half = mneg ? (~prod_ff + HALF + {{(2*W-1){1'b0}}, 1'b1}) : (prod_ff + HALF);
      mq       = mag_half >> FRAC_BITS;
      mlimit   = mneg ? ({{(2*W-1){1'b0}}, 1'b1} << (W - 1))
                      : (({{(2*W-1){1'b0}}, 1'b1} << (W - 1)) - {{(2*W-1){1'b0}}, 1'b1});
      msat     = mq > mlimit;
      info_c_in = info_b_ff;
      if (info_b_ff.is_mul) begin
         info_c_in.ovf = msat;
         if (msat) begin
            info_c_in.result = mneg ? SAT_LO : SAT_HI;
         end else begin
            info_c_in.result = mneg ? (~mq[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : mq[W-1:0];
         end
      end
   end

   // Delay line that keeps the other results aligned with the divider.
   info_type pipe_ff [0:DLY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (enable) begin
         pipe_ff[0] <= info_c_in;
         for (int i = 1; i < DLY; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   logic [W-1:0] div_quo;
   logic         div_ovf;

   fpa_div #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_div (
      .clock   (clock),
      .enable  (enable),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .quo_neg (a_ff[W-1] ^ b_ff[W-1]),
      .quo     (div_quo),
      .quo_ovf (div_ovf)
   );

   // Output register.
   logic signed [PORT_W-1:0] rsp_result_ff;
   logic                     rsp_gt_ff;
   logic                     rsp_lt_ff;
   logic                     rsp_eq_ff;
   logic                     rsp_dz_ff;
   logic                     rsp_ovf_ff;
   logic signed [W-1:0]      final_result;
   logic                     final_ovf;
   logic                     use_div;

   assign use_div      = pipe_ff[DLY-1].is_div && !pipe_ff[DLY-1].dz;
   assign final_result = use_div ? div_quo : pipe_ff[DLY-1].result;
   assign final_ovf    = use_div ? div_ovf : pipe_ff[DLY-1].ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= pipe_ff[DLY-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_result_ff <= PORT_W'(final_result);
         rsp_gt_ff     <= pipe_ff[DLY-1].gt;
         rsp_lt_ff     <= pipe_ff[DLY-1].lt;
         rsp_eq_ff     <= pipe_ff[DLY-1].eq;
         rsp_dz_ff     <= pipe_ff[DLY-1].dz;
         rsp_ovf_ff    <= final_ovf;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_a_greater   = rsp_gt_ff;
   assign rsp_a_less      = rsp_lt_ff;
   assign rsp_a_equal     = rsp_eq_ff;
   assign rsp_div_by_zero = rsp_dz_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_gt_ff, rsp_lt_ff, rsp_eq_ff}))
      else $error("compare flags not exclusive");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dz_ff |-> (rsp_result_ff == '0) && !rsp_ovf_ff)
      else $error("divide by zero word carries a value");

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |->
         (rsp_result_ff[W-1:0] == SAT_HI) || (rsp_result_ff[W-1:0] == SAT_LO))
      else $error("saturated word is not a bound");
endmodule
`default_nettype wire
